[rtl/ebml_block_lacing_parser_core_assert.svh]
// Assertion macros used by the parser's output-side module (ebml_blp_back).
`ifndef EBML_BLOCK_LACING_PARSER_CORE_ASSERT_SVH
`define EBML_BLOCK_LACING_PARSER_CORE_ASSERT_SVH
`define EBML_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ebml lacing parser check failed");
`define EBML_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ebml lacing parser check failed");
`endif

[rtl/ebml_blp_pkg.sv]
package ebml_blp_pkg;
   localparam int MAX_FRAMES = 64;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int LEN_W = 24;
   localparam int TRK_W = 56;
   localparam int SUM_W = 26;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_CORRUPT = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] KEY_FORCE_ON = 2'd1;
   localparam logic [1:0] KEY_FORCE_OFF = 2'd2;

   localparam logic [1:0] LACE_NONE = 2'd0;
   localparam logic [1:0] LACE_XIPH = 2'd1;
   localparam logic [1:0] LACE_FIXED = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE, PH_TRK1, PH_TRKN, PH_TSHI, PH_TSLO, PH_FLAGS, PH_COUNT,
      PH_XIPH, PH_EF1, PH_EFN, PH_ED1, PH_EDN, PH_PAYLOAD
   } phase_type;

   typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_READ, BK_SEND} back_state_type;

   typedef struct packed {
      logic              err;
      logic [1:0]        status;
      logic              fixed;
      logic [TRK_W-1:0]  track;
      logic [15:0]       ts;
      logic              key;
      logic [1:0]        lacing;
      logic [CNT_W-1:0]  count;
      logic [LEN_W-1:0]  offset;
      logic [LEN_W-1:0]  last_size;
   } job_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  data;
   } size_wr_type;
endpackage

[rtl/ebml_blp_front.sv]
module ebml_blp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_block_start,
   input  logic [23:0]               req_block_length,
   input  logic [1:0]                req_key_mode,
   input  logic                      downstream_busy,
   output logic                      push,
   output ebml_blp_pkg::job_type     push_job,
   output ebml_blp_pkg::size_wr_type size_wr
);
   import ebml_blp_pkg::*;

   phase_type          phase_ff, phase_in, e_phase;
   logic [LEN_W-1:0]   left_ff, left_in, e_left, left_dec;
   logic [LEN_W-1:0]   seen_ff, seen_in, e_seen, seen_inc;
   logic [TRK_W-1:0]   acc_ff, acc_in, v_acc;
   logic [2:0]         togo_ff, togo_in, v_togo;
   logic [3:0]         vlen_ff, vlen_in, v_len, len_first;
   logic [23:0]        hdr_ff, hdr_in, e_hdr, hdr_new;
   logic [CNT_W-1:0]   count_ff, count_in, e_count;
   logic [SUM_W-1:0]   sum_ff, sum_in, e_sum, ed_sum;
   logic [LEN_W-1:0]   prev_ff, prev_in, e_prev;
   logic [1:0]         keych_ff, keych_in, e_keych;
   logic [ADDR_W-1:0]  lace_ff, lace_in, e_lace;
   logic [TRK_W-1:0]   track_ff, track_in, e_track;

   logic               accept, zero_len, header, vfirst, v_done, v_bad, fin;
   logic [7:0]         lowmask;
   logic [29:0]        x_acc, x_sum_raw;
   logic [SUM_W-1:0]   x_sum;
   logic [57:0]        bias, s_val;
   logic               s_big;
   logic [8:0]         cnt9;
   logic               ev_err, ev_emit, ev_fixed;
   logic [1:0]         ev_st;
   logic [CNT_W-1:0]   ev_count;
   logic [LEN_W-1:0]   ev_last;

   assign accept = req_valid && !req_stall;
   assign req_stall = downstream_busy &&
      (req_block_start || (phase_ff != PH_IDLE && phase_ff != PH_PAYLOAD));

   always_comb begin
      e_phase = req_block_start ? PH_TRK1 : phase_ff;
      e_left = req_block_start ? req_block_length : left_ff;
      e_seen = req_block_start ? '0 : seen_ff;
      e_hdr = req_block_start ? '0 : hdr_ff;
      e_count = req_block_start ? '0 : count_ff;
      e_sum = req_block_start ? '0 : sum_ff;
      e_prev = req_block_start ? '0 : prev_ff;
      e_keych = req_block_start ? req_key_mode : keych_ff;
      e_lace = req_block_start ? '0 : lace_ff;
      e_track = req_block_start ? '0 : track_ff;
      zero_len = req_block_start && (req_block_length == '0);
      header = !zero_len && e_phase != PH_IDLE && e_phase != PH_PAYLOAD;
      left_dec = e_left - 1'b1;
      seen_inc = e_seen + 1'b1;

      len_first = 4'd8;
      for (int i = 0; i < 8; i++) begin
         if (req_data_byte[i]) len_first = 4'(8 - i);
      end
      lowmask = 8'hFF >> len_first;
      vfirst = e_phase == PH_TRK1 || e_phase == PH_EF1 || e_phase == PH_ED1;
      v_bad = vfirst && req_data_byte == 8'd0;
      v_acc = vfirst ? {48'd0, req_data_byte & lowmask} : {acc_ff[47:0], req_data_byte};
      v_togo = vfirst ? 3'(len_first - 4'd1) : ((togo_ff != 3'd0) ? togo_ff - 3'd1 : 3'd0);
      v_len = vfirst ? len_first : vlen_ff;
      v_done = v_togo == 3'd0;

      x_acc = {1'b0, acc_ff[28:0]} + 30'(req_data_byte);
      x_sum_raw = 30'(e_sum) + x_acc;
      x_sum = (x_sum_raw > 30'h200_0000) ? 26'h200_0000 : x_sum_raw[SUM_W-1:0];

      bias = (58'd1 << (6'(7 * v_len) - 6'd1)) - 58'd1;
      s_val = {2'b00, v_acc} + {34'd0, e_prev} - bias;
      s_big = !s_val[57] && (s_val[56:0] > 57'(left_dec));
      ed_sum = e_sum + SUM_W'(s_val[LEN_W-1:0]);
      fin = ((CNT_W+1)'(e_lace) + (CNT_W+1)'(2)) >= (CNT_W+1)'(e_count);
      cnt9 = {1'b0, req_data_byte} + 9'd1;
      hdr_new = (e_phase == PH_FLAGS) ? {e_hdr[23:8], req_data_byte} : e_hdr;
   end

   // Classification of the current byte: error, frame list ready, size write.
   always_comb begin
      ev_err = 1'b0;
      ev_st = ST_OK;
      ev_emit = 1'b0;
      ev_fixed = 1'b0;
      ev_count = e_count;
      ev_last = left_dec;
      size_wr = '0;
      if (zero_len) begin
         ev_err = 1'b1;
         ev_st = ST_CORRUPT;
      end else begin
         unique case (e_phase)
            PH_TRK1, PH_TRKN: begin
               if (v_bad) begin
                  ev_err = 1'b1;
                  ev_st = ST_CORRUPT;
               end
            end
            PH_FLAGS: begin
               if (req_data_byte[2:1] == LACE_NONE) begin
                  ev_emit = 1'b1;
                  ev_count = CNT_W'(1);
               end
            end
            PH_COUNT: begin
               if (cnt9 > 9'(MAX_FRAMES)) begin
                  ev_err = 1'b1;
                  ev_st = ST_RANGE;
               end else if (e_hdr[2:1] == LACE_FIXED) begin
                  ev_emit = 1'b1;
                  ev_fixed = 1'b1;
                  ev_count = CNT_W'(cnt9);
               end else if (e_hdr[2:1] == LACE_XIPH && req_data_byte == 8'd0) begin
                  ev_emit = 1'b1;
                  ev_count = CNT_W'(1);
               end
            end
            PH_XIPH: begin
               if (req_data_byte != 8'hFF) begin
                  size_wr.we = accept;
                  size_wr.addr = e_lace;
                  size_wr.data = x_acc[LEN_W-1:0];
                  if (fin) begin
                     if (x_sum > SUM_W'(left_dec)) begin
                        ev_err = 1'b1;
                        ev_st = ST_CORRUPT;
                     end else begin
                        ev_emit = 1'b1;
                        ev_last = left_dec - x_sum[LEN_W-1:0];
                     end
                  end
               end else if (x_acc > 30'h1000_0000) begin
                  ev_err = 1'b1;
                  ev_st = ST_RANGE;
               end
            end
            PH_EF1, PH_EFN: begin
               if (v_bad) begin
                  ev_err = 1'b1;
                  ev_st = ST_CORRUPT;
               end else if (v_done) begin
                  if (v_acc > 56'h4000_0000) begin
                     ev_err = 1'b1;
                     ev_st = ST_RANGE;
                  end else if (v_acc > TRK_W'(left_dec)) begin
                     ev_err = 1'b1;
                     ev_st = ST_CORRUPT;
                  end else begin
                     size_wr.we = accept;
                     size_wr.addr = '0;
                     size_wr.data = v_acc[LEN_W-1:0];
                     if (e_count <= CNT_W'(2)) begin
                        ev_emit = 1'b1;
                        ev_last = left_dec - v_acc[LEN_W-1:0];
                     end
                  end
               end
            end
            PH_ED1, PH_EDN: begin
               if (v_bad) begin
                  ev_err = 1'b1;
                  ev_st = ST_CORRUPT;
               end else if (v_done) begin
                  if (s_val[57] || s_big || ed_sum > SUM_W'(left_dec)) begin
                     ev_err = 1'b1;
                     ev_st = ST_CORRUPT;
                  end else begin
                     size_wr.we = accept;
                     size_wr.addr = e_lace;
                     size_wr.data = s_val[LEN_W-1:0];
                     if (fin) begin
                        ev_emit = 1'b1;
                        ev_last = left_dec - ed_sum[LEN_W-1:0];
                     end
                  end
               end
            end
            default: ;
         endcase
         if (header && !ev_err && !ev_emit && left_dec == '0) begin
            ev_err = 1'b1;
            ev_st = ST_CORRUPT;
         end
      end
   end

   always_comb begin
      push = accept && (ev_err || ev_emit);
      push_job.err = ev_err;
      push_job.status = ev_st;
      push_job.fixed = ev_fixed;
      push_job.track = e_track;
      push_job.ts = hdr_new[23:8];
      push_job.key = (e_keych == KEY_FORCE_ON) ? 1'b1 :
                     (e_keych == KEY_FORCE_OFF) ? 1'b0 : hdr_new[7];
      push_job.lacing = hdr_new[2:1];
      push_job.count = ev_count;
      push_job.offset = seen_inc;
      push_job.last_size = ev_last;
   end

   // Next phase.
   always_comb begin
      phase_in = e_phase;
      if (zero_len || ev_err) begin
         phase_in = PH_IDLE;
      end else if (ev_emit) begin
         phase_in = (left_dec != '0) ? PH_PAYLOAD : PH_IDLE;
      end else begin
         unique case (e_phase)
            PH_IDLE:    phase_in = PH_IDLE;
            PH_PAYLOAD: phase_in = (e_left <= LEN_W'(1)) ? PH_IDLE : PH_PAYLOAD;
            PH_TRK1, PH_TRKN: phase_in = v_done ? PH_TSHI : PH_TRKN;
            PH_TSHI:    phase_in = PH_TSLO;
            PH_TSLO:    phase_in = PH_FLAGS;
            PH_FLAGS:   phase_in = PH_COUNT;
            PH_COUNT:   phase_in = (e_hdr[2:1] == LACE_XIPH) ? PH_XIPH : PH_EF1;
            PH_XIPH:    phase_in = PH_XIPH;
            PH_EF1, PH_EFN: phase_in = v_done ? PH_ED1 : PH_EFN;
            PH_ED1, PH_EDN: phase_in = v_done ? PH_ED1 : PH_EDN;
            default:    phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      left_in = e_left;
      seen_in = e_seen;
      acc_in = acc_ff;
      togo_in = togo_ff;
      vlen_in = vlen_ff;
      hdr_in = e_hdr;
      count_in = e_count;
      sum_in = e_sum;
      prev_in = e_prev;
      keych_in = e_keych;
      lace_in = e_lace;
      track_in = e_track;
      if (!zero_len && e_phase == PH_PAYLOAD && e_left != '0) begin
         left_in = left_dec;
      end
      if (header) begin
         left_in = left_dec;
         seen_in = seen_inc;
         case (e_phase)
            PH_TRK1, PH_TRKN: begin
               acc_in = v_acc;
               togo_in = v_togo;
               vlen_in = v_len;
               if (v_done) track_in = v_acc;
            end
            PH_TSHI:  hdr_in = {req_data_byte, 16'd0};
            PH_TSLO:  hdr_in = {e_hdr[23:16], req_data_byte, 8'd0};
            PH_FLAGS: hdr_in = hdr_new;
            PH_COUNT: begin
               count_in = CNT_W'(cnt9);
               acc_in = '0;
            end
            PH_XIPH: begin
               if (req_data_byte != 8'hFF) begin
                  acc_in = '0;
                  sum_in = x_sum;
                  lace_in = e_lace + 1'b1;
               end else begin
                  acc_in = TRK_W'(x_acc);
               end
            end
            PH_EF1, PH_EFN: begin
               acc_in = v_acc;
               togo_in = v_togo;
               vlen_in = v_len;
               if (v_done) begin
                  sum_in = v_acc[SUM_W-1:0];
                  prev_in = v_acc[LEN_W-1:0];
                  lace_in = ADDR_W'(1);
               end
            end
            PH_ED1, PH_EDN: begin
               acc_in = v_acc;
               togo_in = v_togo;
               vlen_in = v_len;
               if (v_done) begin
                  sum_in = ed_sum;
                  prev_in = s_val[LEN_W-1:0];
                  lace_in = e_lace + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seen_ff <= seen_in;
         acc_ff <= acc_in;
         togo_ff <= togo_in;
         vlen_ff <= vlen_in;
         hdr_ff <= hdr_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         prev_ff <= prev_in;
         keych_ff <= keych_in;
         lace_ff <= lace_in;
         track_ff <= track_in;
      end
   end
endmodule

[rtl/ebml_blp_queue.sv]
module ebml_blp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ebml_blp_pkg::job_type push_job,
   input  logic                  pop,
   output logic                  pop_valid,
   output ebml_blp_pkg::job_type pop_job
);
   import ebml_blp_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in = push ? !wr_ff : wr_ff;
      rd_in = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      pop_valid = cnt_ff != 2'd0;
      pop_job = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end
endmodule

[rtl/ebml_blp_back.sv]
module ebml_blp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  ebml_blp_pkg::job_type     q_job,
   output logic                      q_pop,
   output logic                      busy,
   input  ebml_blp_pkg::size_wr_type size_wr,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [55:0]               rsp_track_number,
   output logic signed [15:0]        rsp_rel_timestamp,
   output logic                      rsp_key_frame,
   output logic [1:0]                rsp_lacing_kind,
   output logic [7:0]                rsp_frame_index,
   output logic [23:0]               rsp_frame_offset,
   output logic [30:0]               rsp_frame_size,
   output logic                      rsp_last,
   output logic [1:0]                rsp_status
);
   import ebml_blp_pkg::*;
   `include "ebml_block_lacing_parser_core_assert.svh"

   localparam logic [4:0] DIV_LAST = 5'(LEN_W - 1);

   logic [LEN_W-1:0] mem [MAX_FRAMES];
   logic [LEN_W-1:0] rd_ff;

   back_state_type   st_ff, st_in;
   job_type          job_ff, job_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] off_ff, off_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] quo_ff, quo_in;
   logic [4:0]       div_cnt_ff, div_cnt_in;

   logic             slot_free, is_last, div_bad;
   logic [CNT_W:0]   div_sh, div_sub;
   logic             div_ge;
   logic [LEN_W-1:0] cur_size;

   logic             rsp_valid_ff, rsp_valid_in, rsp_key_ff, rsp_key_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [55:0]      rsp_track_ff, rsp_track_in;
   logic [15:0]      rsp_ts_ff, rsp_ts_in;
   logic [1:0]       rsp_lace_ff, rsp_lace_in, rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_index_ff, rsp_index_in;
   logic [23:0]      rsp_off_ff, rsp_off_in;
   logic [30:0]      rsp_size_ff, rsp_size_in;

   always_ff @(posedge clock) begin
      if (size_wr.we) mem[size_wr.addr] <= size_wr.data;
      rd_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      q_pop = (st_ff == BK_IDLE) && q_valid;
      busy = st_ff != BK_IDLE;
      is_last = idx_ff == job_ff.count - 1'b1;
      div_sh = {rem_ff, quo_ff[LEN_W-1]};
      div_ge = div_sh >= {1'b0, job_ff.count};
      div_sub = div_sh - {1'b0, job_ff.count};
      div_bad = (div_ge ? div_sub : div_sh) != '0;
      cur_size = (job_ff.fixed || is_last) ? job_ff.last_size : rd_ff;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BK_IDLE: begin
            if (q_valid) begin
               st_in = q_job.err ? BK_SEND : (q_job.fixed ? BK_DIV : BK_READ);
            end
         end
         BK_DIV: begin
            if (div_cnt_ff == DIV_LAST) st_in = div_bad ? BK_SEND : BK_READ;
         end
         BK_READ: st_in = BK_SEND;
         BK_SEND: begin
            if (slot_free) st_in = (job_ff.err || is_last) ? BK_IDLE : BK_READ;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_in = job_ff;
      idx_in = idx_ff;
      off_in = off_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_cnt_in = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_track_in = rsp_track_ff;
      rsp_ts_in = rsp_ts_ff;
      rsp_key_in = rsp_key_ff;
      rsp_lace_in = rsp_lace_ff;
      rsp_index_in = rsp_index_ff;
      rsp_off_in = rsp_off_ff;
      rsp_size_in = rsp_size_ff;
      rsp_last_in = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      unique case (st_ff)
         BK_IDLE: begin
            if (q_valid) begin
               job_in = q_job;
               idx_in = '0;
               off_in = q_job.offset;
               rem_in = '0;
               quo_in = q_job.last_size;
               div_cnt_in = '0;
            end
         end
         BK_DIV: begin
            rem_in = div_ge ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0];
            quo_in = {quo_ff[LEN_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_LAST) begin
               job_in.last_size = quo_in;
               if (div_bad) begin
                  job_in.err = 1'b1;
                  job_in.status = ST_CORRUPT;
               end
            end
         end
         BK_READ: ;
         BK_SEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (job_ff.err) begin
                  rsp_track_in = '0;
                  rsp_ts_in = '0;
                  rsp_key_in = 1'b0;
                  rsp_lace_in = '0;
                  rsp_index_in = '0;
                  rsp_off_in = '0;
                  rsp_size_in = '0;
                  rsp_last_in = 1'b1;
                  rsp_status_in = job_ff.status;
               end else begin
                  rsp_track_in = job_ff.track;
                  rsp_ts_in = job_ff.ts;
                  rsp_key_in = job_ff.key;
                  rsp_lace_in = job_ff.lacing;
                  rsp_index_in = 8'(idx_ff);
                  rsp_off_in = off_ff;
                  rsp_size_in = 31'(cur_size);
                  rsp_last_in = is_last;
                  rsp_status_in = ST_OK;
                  off_in = off_ff + cur_size;
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
      off_ff <= off_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_cnt_ff <= div_cnt_in;
      rsp_track_ff <= rsp_track_in;
      rsp_ts_ff <= rsp_ts_in;
      rsp_key_ff <= rsp_key_in;
      rsp_lace_ff <= rsp_lace_in;
      rsp_index_ff <= rsp_index_in;
      rsp_off_ff <= rsp_off_in;
      rsp_size_ff <= rsp_size_in;
      rsp_last_ff <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_track_number = rsp_track_ff;
   assign rsp_rel_timestamp = rsp_ts_ff;
   assign rsp_key_frame = rsp_key_ff;
   assign rsp_lacing_kind = rsp_lace_ff;
   assign rsp_frame_index = rsp_index_ff;
   assign rsp_frame_offset = rsp_off_ff;
   assign rsp_frame_size = rsp_size_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   `EBML_ASSERT_SAME(a_wr_while_idle, clock, reset, size_wr.we, st_ff == BK_IDLE)
   `EBML_ASSERT_SAME(a_idx_in_range, clock, reset, st_ff == BK_SEND && !job_ff.err, idx_ff < job_ff.count)
   `EBML_ASSERT_NEXT(a_div_ends, clock, reset, st_ff == BK_DIV && div_cnt_ff == DIV_LAST, st_ff == BK_READ || st_ff == BK_SEND)
endmodule

[rtl/ebml_block_lacing_parser_core.sv]
// Matroska block lacing parser. Block bytes enter one per cycle while req_stall is low; the
// parser reads the track number, timestamp, flags and lace sizes and, once the header is
// complete, hands a frame list to the output side, which sends one descriptor per frame (or
// one error transfer per bad block), each descriptor through a size-memory read and then the
// output register. Fixed lacing adds a bit-serial division of the remaining length by the frame count.
// Payload bytes keep flowing while descriptors drain; the header bytes of the next block
// wait until the output side has moved the last descriptor of the previous block into its
// output register, so a stalled result channel holds them back as well.
module ebml_block_lacing_parser_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_block_start,
   input  logic [23:0]        req_block_length,
   input  logic [1:0]         req_key_mode,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [55:0]        rsp_track_number,
   output logic signed [15:0] rsp_rel_timestamp,
   output logic               rsp_key_frame,
   output logic [1:0]         rsp_lacing_kind,
   output logic [7:0]         rsp_frame_index,
   output logic [23:0]        rsp_frame_offset,
   output logic [30:0]        rsp_frame_size,
   output logic               rsp_last,
   output logic [1:0]         rsp_status
);
   import ebml_blp_pkg::*;

   logic        push, pop, q_valid, back_busy;
   job_type     push_job, q_job;
   size_wr_type size_wr;

   ebml_blp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte, .req_block_start,
      .req_block_length, .req_key_mode,
      .downstream_busy(q_valid || back_busy),
      .push, .push_job, .size_wr
   );

   ebml_blp_queue u_queue (
      .clock, .reset, .push, .push_job, .pop,
      .pop_valid(q_valid), .pop_job(q_job)
   );

   ebml_blp_back u_back (
      .clock, .reset, .q_valid, .q_job, .q_pop(pop), .busy(back_busy), .size_wr,
      .rsp_valid, .rsp_stall, .rsp_track_number, .rsp_rel_timestamp, .rsp_key_frame,
      .rsp_lacing_kind, .rsp_frame_index, .rsp_frame_offset, .rsp_frame_size,
      .rsp_last, .rsp_status
   );
endmodule

[verif/ebml_block_lacing_parser_core_checker.sv]
module ebml_block_lacing_parser_core_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_block_start,
   input  logic [23:0]        req_block_length,
   input  logic [1:0]         req_key_mode,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [55:0]        rsp_track_number,
   input  logic signed [15:0] rsp_rel_timestamp,
   input  logic               rsp_key_frame,
   input  logic [1:0]         rsp_lacing_kind,
   input  logic [7:0]         rsp_frame_index,
   input  logic [23:0]        rsp_frame_offset,
   input  logic [30:0]        rsp_frame_size,
   input  logic               rsp_last,
   input  logic [1:0]         rsp_status,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ebml_blp_pkg::*;

   typedef struct packed {
      logic [55:0] track;
      logic [15:0] ts;
      logic        key;
      logic [1:0]  lacing;
      logic [7:0]  index;
      logic [23:0] offset;
      logic [30:0] size;
      logic        last;
      logic [1:0]  status;
   } frame_desc_type;

   frame_desc_type expected_frames[$];

   phase_type   phase;
   logic [31:0] left_bytes, seen_bytes, header_word, sizes_sum, prior_size;
   logic [63:0] vint_value, track_word;
   int          vint_remaining, vint_length, lace_index, lace_total;
   logic [1:0]  key_select;
   logic [31:0] frame_len_store [MAX_FRAMES];

   function automatic void queue_error(logic [1:0] st);
      frame_desc_type d;
      d = '0;
      d.last = 1'b1;
      d.status = st;
      expected_frames.push_back(d);
      phase = PH_IDLE;
   endfunction

   function automatic void queue_frames();
      frame_desc_type d;
      logic [31:0] off;
      logic key;
      off = seen_bytes;
      if (key_select == KEY_FORCE_ON) key = 1'b1;
      else if (key_select == KEY_FORCE_OFF) key = 1'b0;
      else key = header_word[7];
      for (int i = 0; i < lace_total; i++) begin
         d.track = track_word[55:0];
         d.ts = header_word[23:8];
         d.key = key;
         d.lacing = header_word[2:1];
         d.index = i[7:0];
         d.offset = off[23:0];
         d.size = frame_len_store[i][30:0];
         d.last = (i + 1 == lace_total);
         d.status = ST_OK;
         expected_frames.push_back(d);
         off += frame_len_store[i];
      end
      phase = (left_bytes != 0) ? PH_PAYLOAD : PH_IDLE;
   endfunction

   function automatic int vint_take(logic [7:0] b, bit first);
      logic [7:0] mask;
      int len;
      if (first) begin
         if (b == 8'h00) return -1;
         mask = 8'h80;
         len = 1;
         while ((b & mask) == 0) begin
            mask >>= 1;
            len++;
         end
         vint_value = {56'd0, b & (mask - 8'd1)};
         vint_remaining = len - 1;
         vint_length = len;
      end else begin
         vint_value = (vint_value << 8) | {56'd0, b};
         if (vint_remaining > 0) vint_remaining--;
      end
      return (vint_remaining == 0) ? 1 : 0;
   endfunction

   function automatic void close_lace();
      if (sizes_sum > left_bytes) begin
         queue_error(ST_CORRUPT);
         return;
      end
      frame_len_store[lace_total - 1] = left_bytes - sizes_sum;
      queue_frames();
   endfunction

   function automatic void predict_block_byte(logic [7:0] b, logic st, logic [23:0] len,
                                              logic [1:0] km);
      int v;
      logic [1:0] lacing;
      longint bias, s;
      if (st) begin
         left_bytes = {8'd0, len};
         seen_bytes = 0;
         key_select = km;
         header_word = 0;
         track_word = 0;
         lace_total = 0;
         sizes_sum = 0;
         prior_size = 0;
         lace_index = 0;
         phase = PH_TRK1;
         if (left_bytes == 0) begin
            queue_error(ST_CORRUPT);
            return;
         end
      end
      if (phase == PH_IDLE) return;
      if (phase == PH_PAYLOAD) begin
         if (left_bytes != 0) left_bytes--;
         if (left_bytes == 0) phase = PH_IDLE;
         return;
      end
      seen_bytes++;
      left_bytes--;
      lacing = header_word[2:1];
      case (phase)
         PH_TRK1, PH_TRKN: begin
            v = vint_take(b, phase == PH_TRK1);
            if (v < 0) begin
               queue_error(ST_CORRUPT);
               return;
            end
            if (v != 0) begin
               track_word = vint_value;
               phase = PH_TSHI;
            end else phase = PH_TRKN;
         end
         PH_TSHI: begin
            header_word = {8'd0, b, 16'd0};
            phase = PH_TSLO;
         end
         PH_TSLO: begin
            header_word[15:8] = b;
            phase = PH_FLAGS;
         end
         PH_FLAGS: begin
            header_word[7:0] = b;
            if (b[2:1] == LACE_NONE) begin
               lace_total = 1;
               frame_len_store[0] = left_bytes;
               queue_frames();
               return;
            end
            phase = PH_COUNT;
         end
         PH_COUNT: begin
            if (int'(b) + 1 > MAX_FRAMES) begin
               queue_error(ST_RANGE);
               return;
            end
            lace_total = int'(b) + 1;
            if (lacing == LACE_FIXED) begin
               if (left_bytes % lace_total != 0) begin
                  queue_error(ST_CORRUPT);
                  return;
               end
               for (int i = 0; i < lace_total; i++)
                  frame_len_store[i] = left_bytes / lace_total;
               queue_frames();
               return;
            end
            if (lacing == LACE_XIPH) begin
               if (lace_total == 1) begin
                  frame_len_store[0] = left_bytes;
                  queue_frames();
                  return;
               end
               vint_value = 0;
               phase = PH_XIPH;
            end else phase = PH_EF1;
         end
         PH_XIPH: begin
            vint_value += {56'd0, b};
            if (b != 8'd255) begin
               if (lace_index < MAX_FRAMES) frame_len_store[lace_index] = vint_value[31:0];
               sizes_sum += vint_value[31:0];
               if (sizes_sum > 32'h0200_0000) sizes_sum = 32'h0200_0000;
               vint_value = 0;
               lace_index++;
               if (lace_index + 1 >= lace_total) begin
                  close_lace();
                  return;
               end
            end else if (vint_value > 64'h1000_0000) begin
               queue_error(ST_RANGE);
               return;
            end
         end
         PH_EF1, PH_EFN: begin
            v = vint_take(b, phase == PH_EF1);
            if (v < 0) begin
               queue_error(ST_CORRUPT);
               return;
            end
            if (v == 0) phase = PH_EFN;
            else begin
               if (vint_value > 64'h4000_0000) begin
                  queue_error(ST_RANGE);
                  return;
               end
               if (vint_value > {32'd0, left_bytes}) begin
                  queue_error(ST_CORRUPT);
                  return;
               end
               sizes_sum = vint_value[31:0];
               prior_size = sizes_sum;
               frame_len_store[0] = sizes_sum;
               lace_index = 1;
               if (lace_total <= 2) begin
                  close_lace();
                  return;
               end
               phase = PH_ED1;
            end
         end
         PH_ED1, PH_EDN: begin
            v = vint_take(b, phase == PH_ED1);
            if (v < 0) begin
               queue_error(ST_CORRUPT);
               return;
            end
            if (v == 0) phase = PH_EDN;
            else begin
               bias = (longint'(1) <<< (7 * vint_length - 1)) - 1;
               s = longint'({32'd0, prior_size}) + longint'(vint_value) - bias;
               if (s < 0 || s > longint'({32'd0, left_bytes})) begin
                  queue_error(ST_CORRUPT);
                  return;
               end
               sizes_sum += s[31:0];
               if (sizes_sum > left_bytes) begin
                  queue_error(ST_CORRUPT);
                  return;
               end
               if (lace_index < MAX_FRAMES) frame_len_store[lace_index] = s[31:0];
               prior_size = s[31:0];
               lace_index++;
               if (lace_index + 1 >= lace_total) begin
                  close_lace();
                  return;
               end
               phase = PH_ED1;
            end
         end
         default: begin
            phase = PH_IDLE;
            return;
         end
      endcase
      if (left_bytes == 0) queue_error(ST_CORRUPT);
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
      phase = PH_IDLE;
      left_bytes = 0;
      seen_bytes = 0;
      header_word = 0;
      sizes_sum = 0;
      prior_size = 0;
      vint_value = 0;
      track_word = 0;
      vint_remaining = 0;
      vint_length = 0;
      lace_index = 0;
      lace_total = 0;
      key_select = 0;
   end

   always @(posedge clock) begin
      frame_desc_type got, want;
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_block_byte(req_data_byte, req_block_start, req_block_length, req_key_mode);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_track_number, rsp_rel_timestamp, rsp_key_frame, rsp_lacing_kind,
                   rsp_frame_index, rsp_frame_offset, rsp_frame_size, rsp_last, rsp_status};
            if (expected_frames.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("Unexpected descriptor: %p", got);
            end else begin
               want = expected_frames.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("Descriptor mismatch: expected %p, actual %p", want, got);
               end
            end
         end
         pending_count = expected_frames.size();
      end
   end
endmodule

[verif/ebml_block_lacing_parser_core_test.sv]
module ebml_block_lacing_parser_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ebml_blp_pkg::*;

   typedef struct {
      logic [7:0]  data;
      logic        start;
      logic [23:0] len;
      logic [1:0]  km;
   } block_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = '0;
   logic               req_block_start = 1'b0;
   logic [23:0]        req_block_length = '0;
   logic [1:0]         req_key_mode = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [55:0]        rsp_track_number;
   logic signed [15:0] rsp_rel_timestamp;
   logic               rsp_key_frame;
   logic [1:0]         rsp_lacing_kind;
   logic [7:0]         rsp_frame_index;
   logic [23:0]        rsp_frame_offset;
   logic [30:0]        rsp_frame_size;
   logic               rsp_last;
   logic [1:0]         rsp_status;
   int                 fail_count, pending_count;

   block_byte_type byte_stream[$];
   bit quiet_phase = 0;
   bit long_hold_due = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ebml_block_lacing_parser_core dut (.*);

   ebml_block_lacing_parser_core_checker checker_inst (.*);

   task automatic push_byte(logic [7:0] b, logic st, logic [23:0] len, logic [1:0] km);
      block_byte_type it;
      it.data = b;
      it.start = st;
      it.len = st ? len : 24'($urandom);
      it.km = st ? km : 2'($urandom);
      byte_stream.push_back(it);
   endtask

   task automatic send_block(logic [7:0] hdr[$], int payload, logic [23:0] len,
                             logic [1:0] km);
      for (int i = 0; i < hdr.size(); i++) push_byte(hdr[i], i == 0, len, km);
      repeat (payload) push_byte(8'($urandom), 1'b0, 24'd0, 2'd0);
   endtask

   task automatic random_block();
      logic [7:0] h[$];
      int sz[$];
      int kind, n, payload, total, mut, d, raw, s;
      kind = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: h.push_back(8'h80 | 8'($urandom_range(0, 127)));
         6, 7, 8: begin
            h.push_back(8'h40 | 8'($urandom_range(0, 63)));
            h.push_back(8'($urandom));
         end
         default: begin
            h.push_back(8'h01);
            repeat (7) h.push_back(8'($urandom));
         end
      endcase
      h.push_back(8'($urandom));
      h.push_back(8'($urandom));
      h.push_back((8'($urandom) & 8'hF9) | 8'(kind << 1));
      n = (kind == 0) ? 1 : $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         sz.push_back(($urandom_range(0, 14) == 0) ? $urandom_range(250, 300)
                                                    : $urandom_range(0, 12));
      if (kind == 2) for (int i = 1; i < n; i++) sz[i] = sz[0];
      if (kind != 0) h.push_back(8'(n - 1));
      if (kind == 1) begin
         for (int i = 0; i < n - 1; i++) begin
            s = sz[i];
            while (s >= 255) begin
               h.push_back(8'd255);
               s -= 255;
            end
            h.push_back(8'(s));
         end
      end else if (kind == 3 && n > 1) begin
         if (sz[0] < 127) h.push_back(8'h80 | 8'(sz[0]));
         else begin
            h.push_back(8'h40 | 8'(sz[0] >> 8));
            h.push_back(8'(sz[0]));
         end
         for (int i = 1; i < n - 1; i++) begin
            d = sz[i] - sz[i-1];
            if (d >= -63 && d <= 63) h.push_back(8'h80 | 8'(d + 63));
            else begin
               raw = d + 8191;
               h.push_back(8'h40 | 8'(raw >> 8));
               h.push_back(8'(raw));
            end
         end
      end
      payload = 0;
      foreach (sz[i]) payload += sz[i];
      total = h.size() + payload;
      mut = $urandom_range(0, 9);
      if (mut == 0) h[$urandom_range(0, h.size() - 1)] = 8'($urandom);
      else if (mut == 1) begin
         total -= $urandom_range(1, 3);
         if (total < 1) total = 1;
      end else if (mut == 2) begin
         total = $urandom;
         payload = $urandom_range(0, 3);
      end else if (mut == 3) total += $urandom_range(1, 3);
      send_block(h, payload, 24'(total), 2'($urandom));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 24'd0, 2'd0);
   endtask

   task automatic directed_blocks();
      push_byte(8'($urandom), 1'b1, 24'd0, 2'd0);
      send_block('{8'h00, 8'h01, 8'h02, 8'h03}, 0, 24'd4, 2'd0);
      send_block('{8'h81, 8'h80, 8'h00, 8'h80}, 1, 24'd5, 2'd0);
      send_block('{8'hFF, 8'h7F, 8'hFF, 8'h00}, 0, 24'd4, 2'd1);
      send_block('{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hAA, 8'h55, 8'h01}, 0, 24'd11, 2'd2);
      send_block('{8'h81, 8'h00, 8'h00, 8'h04, 8'h40}, 0, 24'd5, 2'd3);
      send_block('{8'h81, 8'h00, 8'h00, 8'h04, 8'h3F}, 0, 24'd5, 2'd0);
      send_block('{8'h81, 8'h00, 8'h00, 8'h04, 8'h01}, 3, 24'd8, 2'd0);
      send_block('{8'h81, 8'h00, 8'h00, 8'h06, 8'h02, 8'h82, 8'h80}, 0, 24'd12, 2'd0);
      send_block('{8'h81, 8'h00, 8'h00}, 0, 24'd3, 2'd0);
      send_block('{8'h81, 8'h12, 8'h34, 8'h02, 8'h02, 8'h02, 8'h01}, 4, 24'd11, 2'd0);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet_phase) repeat ($urandom_range(0, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int total;
      directed_blocks();
      while (byte_stream.size() < 200) random_block();
      total = byte_stream.size();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < total; i++) begin
         if (i == total / 2) long_hold_due = 1;
         if (i >= total * 85 / 100) quiet_phase = 1;
         if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= byte_stream[i].data;
         req_block_start <= byte_stream[i].start;
         req_block_length <= byte_stream[i].len;
         req_key_mode <= byte_stream[i].km;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
